[rtl/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, request/response transactions and the scan/update
// structs that travel along the row of cache cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  // Store geometry
  localparam int MAX_ENTRIES_DEF   = 16;
  localparam int MAX_ENTRIES_LIMIT = 256;
  localparam int SLOT_W            = $clog2(MAX_ENTRIES_LIMIT);
  localparam int CNT_W             = SLOT_W + 1;

  // Field widths
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Request kinds
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  // Value returned by a get that misses
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] lookup_key;
    logic signed [DATA_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                     key_found;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

  // Token carried from cell to cell during a lookup
  typedef struct packed {
    logic              hit;
    slot_t             hit_slot;
    slot_t             hit_rank;
    logic [DATA_W-1:0] hit_data;
    slot_t             victim_slot;
  } scan_t;

  // Update broadcast to all cells at the end of a transaction
  typedef struct packed {
    logic              apply;
    slot_t             target;
    cnt_t              thresh;
    logic              write_key;
    logic              write_data;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] data;
  } upd_t;

endpackage

`default_nettype wire

[rtl/lkv_cell.sv]
// ----------------------------------------------------------------------------
// LRU cache cell
// Holds one key/value slot and its recency rank. Folds its own match and
// eviction candidate into the scan token and hands it to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkv_cell
  import lkv_pkg::*;
#(
  parameter int MaxEntries = MAX_ENTRIES_DEF,
  parameter int Index      = 0
) (
  input  logic              clk,
  input  scan_t             scan_in,
  output scan_t             scan_out,
  input  logic [DATA_W-1:0] lookup_key,
  input  cnt_t              fill_count,
  input  upd_t              upd
);

  localparam int   RankW  = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam cnt_t MyPos  = CNT_W'(Index);
  localparam slot_t MySlot = SLOT_W'(Index);

  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] data;
  logic [RankW-1:0]  rank;

  logic  valid;
  cnt_t  rank_ext;
  scan_t scan_next;

  assign valid    = MyPos < fill_count;
  assign rank_ext = CNT_W'(rank);

  // Fold this slot into the passing token
  always_comb begin
    scan_next = scan_in;
    if (valid && !scan_in.hit && (key == lookup_key)) begin
      scan_next.hit      = 1'b1;
      scan_next.hit_slot = MySlot;
      scan_next.hit_rank = SLOT_W'(rank);
      scan_next.hit_data = data;
    end
    if (valid && (rank_ext == (fill_count - CNT_W'(1)))) begin
      scan_next.victim_slot = MySlot;
    end
  end

  // Advance the token one cell per cycle
  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

  // Apply the broadcast update: promote the target, age the newer entries
  always_ff @(posedge clk) begin
    if (upd.apply) begin
      if (upd.target == MySlot) begin
        rank <= '0;
        if (upd.write_key) begin
          key <= upd.key;
        end
        if (upd.write_data) begin
          data <= upd.data;
        end
      end else if (valid && (rank_ext < upd.thresh)) begin
        rank <= rank + RankW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement,
// built as a row of slot cells that a lookup token walks through.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the transaction is taken at
//   a clock edge where start is high and busy is low. busy stays high until
//   the request has been processed.
//   Response channel: done is high for exactly one cycle with rsp valid.
//   The receiver cannot stall; it must take rsp in that cycle.
//   Configuration: cfg_wr_en writes cfg_wr_data into the capacity register;
//   write only while busy is low and no response is pending.
// Timing:
//   The lookup token moves one cell per cycle; a request stays in the scan
//   state while the token crosses every cell of the row, then in the
//   update state, and done is registered from the update state. busy falls
//   in the cycle in which done is high, so a new request may be issued
//   alongside done; transactions never overlap, paced by the cell row.
// Reset:
//   rst (synchronous) empties the store and sets capacity to 16. No
//   clearing pass is needed; slots beyond the fill count are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MaxEntries = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t            state;
  logic [IdxW-1:0]   cnt;
  req_t              req_q;
  logic [CntW-1:0]   fill_count;
  logic [CAP_W-1:0]  capacity;

  scan_t             scan_link [0:MaxEntries];
  scan_t             fin;
  upd_t              upd;
  rsp_t              rsp_next;
  logic              fill_inc;
  logic [CmpW-1:0]   cap_ext;
  logic [CmpW-1:0]   cap_eff;
  logic              full;

  assign busy = (state != ST_IDLE);

  // Row of slot cells
  assign scan_link[0] = '0;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    lkv_cell #(
      .MaxEntries (MaxEntries),
      .Index      (i)
    ) u_cell (
      .clk        (clk),
      .scan_in    (scan_link[i]),
      .scan_out   (scan_link[i+1]),
      .lookup_key (req_q.lookup_key),
      .fill_count (CNT_W'(fill_count)),
      .upd        (upd)
    );
  end

  assign fin = scan_link[MaxEntries];

  // Clamp capacity to 1..MaxEntries and check for a full store
  always_comb begin
    cap_ext = CmpW'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(MaxEntries)) begin
      cap_eff = CmpW'(MaxEntries);
    end else begin
      cap_eff = cap_ext;
    end
    full = CmpW'(fill_count) >= cap_eff;
  end

  // Decide the update and the response from the finished token
  always_comb begin
    upd            = '0;
    upd.key        = req_q.lookup_key;
    upd.data       = req_q.write_value;
    fill_inc       = 1'b0;
    rsp_next       = '0;
    rsp_next.key_found = fin.hit;
    unique case (req_q.req_type)
      REQ_GET: begin
        if (fin.hit) begin
          upd.apply           = 1'b1;
          upd.target          = fin.hit_slot;
          upd.thresh          = CNT_W'(fin.hit_rank);
          rsp_next.read_value = fin.hit_data;
        end else begin
          rsp_next.read_value = MISS_VALUE;
        end
      end
      REQ_SET: begin
        upd.apply      = 1'b1;
        upd.write_data = 1'b1;
        if (fin.hit) begin
          upd.target = fin.hit_slot;
          upd.thresh = CNT_W'(fin.hit_rank);
        end else if (full) begin
          upd.write_key = 1'b1;
          upd.target    = fin.victim_slot;
          upd.thresh    = CNT_W'(fill_count) - CNT_W'(1);
        end else begin
          upd.write_key = 1'b1;
          upd.target    = SLOT_W'(fill_count);
          upd.thresh    = CNT_W'(fill_count);
          fill_inc      = 1'b1;
        end
      end
      default: begin
        rsp_next.read_value = MISS_VALUE;
      end
    endcase
    if (state != ST_UPDATE) begin
      upd.apply = 1'b0;
      fill_inc  = 1'b0;
    end
  end

  // Sequencer, fill count, capacity and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      fill_count <= '0;
      capacity   <= CAP_RESET;
      done       <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE);
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt == IdxW'(MaxEntries - 1)) begin
            state <= ST_UPDATE;
          end else begin
            cnt <= cnt + IdxW'(1);
          end
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
          if (fill_inc) begin
            fill_count <= fill_count + CntW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the request and the response payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (state == ST_UPDATE) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CntW'(MaxEntries))
    else $error("fill count above store depth");

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("response strobe without an update cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fill_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(fill_count)) |-> $past(state == ST_UPDATE))
    else $error("fill count changed outside the update cycle");
`endif

endmodule

`default_nettype wire
